### rtl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// pbb_pkg
// shared formats, blend modes, register indexes, pixel codecs and types
// ----------------------------------------------------------------------------
package pbb_pkg;

    localparam logic [2:0] FMT_RGB565   = 3'd0;
    localparam logic [2:0] FMT_RGBA8888 = 3'd1;
    localparam logic [2:0] FMT_ARGB8888 = 3'd2;
    localparam logic [2:0] FMT_RGBA4444 = 3'd3;
    localparam logic [2:0] FMT_IDX8     = 3'd4;
    localparam logic [2:0] FMT_IDX8A    = 3'd5;

    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_ALPHA = 2'd1;
    localparam logic [1:0] MODE_KEY   = 2'd2;
    localparam logic [1:0] MODE_ADD   = 2'd3;

    localparam logic [2:0] REG_SRC_FORMAT  = 3'd0;
    localparam logic [2:0] REG_DST_FORMAT  = 3'd1;
    localparam logic [2:0] REG_BLEND_MODE  = 3'd2;
    localparam logic [2:0] REG_LAYER_ALPHA = 3'd3;
    localparam logic [2:0] REG_KEY_RGB     = 3'd4;

    localparam logic [31:0] DIV255_RECIP = 32'h0000_8081;

    typedef struct packed {
        logic [2:0]  src_format;
        logic [2:0]  dst_format;
        logic [1:0]  blend_mode;
        logic [7:0]  layer_alpha;
        logic [23:0] key_rgb;
    } t_cfg;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_argb;

    // shift-based divide by 255, exact for products of two 8-bit values
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [31:0] p;
        p = {16'd0, v} * DIV255_RECIP;
        return p[30:23];
    endfunction

    function automatic t_argb decode_pixel(input logic [31:0] raw, input logic [2:0] fmt);
        t_argb c;
        unique case (fmt)
            FMT_RGB565: begin
                c = {8'hFF, raw[15:11], 3'd0, raw[10:5], 2'd0, raw[4:0], 3'd0};
            end
            FMT_RGBA8888: begin
                c = {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
            end
            FMT_ARGB8888: begin
                c = raw;
            end
            FMT_RGBA4444: begin
                c = {raw[3:0], 4'd0, raw[15:12], 4'd0, raw[11:8], 4'd0, raw[7:4], 4'd0};
            end
            FMT_IDX8: begin
                c = {8'hFF, raw[7:0], raw[7:0], raw[7:0]};
            end
            FMT_IDX8A: begin
                c = 32'hFF00_0000;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic [31:0] encode_pixel(input t_argb c, input logic [2:0] fmt);
        logic [31:0] w;
        unique case (fmt)
            FMT_RGB565: begin
                w = {16'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
            end
            FMT_RGBA8888: begin
                w = {c.a, c.b, c.g, c.r};
            end
            FMT_ARGB8888: begin
                w = c;
            end
            FMT_RGBA4444: begin
                w = {16'd0, c.r[7:4], c.g[7:4], c.b[7:4], c.a[7:4]};
            end
            default: begin
                w = {24'd0, c.b};
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/pbb_unpack.sv
// ----------------------------------------------------------------------------
// pbb_unpack
// first pipeline stage: decodes source and destination words to argb8888
// ----------------------------------------------------------------------------
module pbb_unpack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pbb_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [31:0]   i_src_raw,
    input  logic [31:0]   i_dst_raw,
    output logic          o_valid,
    output pbb_pkg::t_argb o_src,
    output pbb_pkg::t_argb o_dst
);
    import pbb_pkg::*;

    logic  r_valid;
    t_argb r_src;
    t_argb r_dst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= decode_pixel(i_src_raw, i_cfg.src_format);
        r_dst <= decode_pixel(i_dst_raw, i_cfg.dst_format);
    end

    assign o_valid = r_valid;
    assign o_src   = r_src;
    assign o_dst   = r_dst;

endmodule

### rtl/pbb_blend.sv
// ----------------------------------------------------------------------------
// pbb_blend
// four stages: alpha scale product, exact divide by 255, channel products,
// normalize and mode select
// ----------------------------------------------------------------------------
module pbb_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbb_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  pbb_pkg::t_argb i_src,
    input  pbb_pkg::t_argb i_dst,
    output logic           o_valid,
    output logic           o_we,
    output pbb_pkg::t_argb o_res
);
    import pbb_pkg::*;

    // stage 2: source alpha times layer alpha
    logic        r2_valid;
    t_argb       r2_src;
    t_argb       r2_dst;
    logic [15:0] r2_prod;

    // stage 3: scaled alpha
    logic        r3_valid;
    t_argb       r3_src;
    t_argb       r3_dst;
    logic [7:0]  r3_sa;

    // stage 4: weighted sums
    logic        r4_valid;
    t_argb       r4_src;
    t_argb       r4_dst;
    logic [7:0]  r4_sa;
    logic [15:0] r4_sum_r;
    logic [15:0] r4_sum_g;
    logic [15:0] r4_sum_b;
    logic [15:0] r4_sum_a;

    // stage 5: result
    logic        r5_valid;
    logic        r5_we;
    t_argb       r5_res;

    logic [31:0] n3_scaled;
    logic [7:0]  n4_inv;
    t_argb       n5_res;
    logic        n5_we;
    logic [8:0]  n5_add_r;
    logic [8:0]  n5_add_g;
    logic [8:0]  n5_add_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r2_valid <= i_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    assign n3_scaled = {16'd0, r2_prod} * DIV255_RECIP;
    assign n4_inv    = 8'hFF - r3_sa;
    assign n5_add_r  = {1'b0, r4_src.r} + {1'b0, r4_dst.r};
    assign n5_add_g  = {1'b0, r4_src.g} + {1'b0, r4_dst.g};
    assign n5_add_b  = {1'b0, r4_src.b} + {1'b0, r4_dst.b};

    always_comb begin
        n5_res = r4_src;
        n5_we  = 1'b1;
        case (i_cfg.blend_mode)
            MODE_ALPHA: begin
                n5_res.a = r4_sa + div255(r4_sum_a);
                n5_res.r = div255(r4_sum_r);
                n5_res.g = div255(r4_sum_g);
                n5_res.b = div255(r4_sum_b);
            end
            MODE_KEY: begin
                n5_we = ({r4_src.r, r4_src.g, r4_src.b} != i_cfg.key_rgb);
            end
            MODE_ADD: begin
                n5_res.a = 8'hFF;
                n5_res.r = n5_add_r[8] ? 8'hFF : n5_add_r[7:0];
                n5_res.g = n5_add_g[8] ? 8'hFF : n5_add_g[7:0];
                n5_res.b = n5_add_b[8] ? 8'hFF : n5_add_b[7:0];
            end
            default: begin
                n5_res = r4_src;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_src   <= i_src;
        r2_dst   <= i_dst;
        r2_prod  <= {8'd0, i_src.a} * {8'd0, i_cfg.layer_alpha};

        r3_src   <= r2_src;
        r3_dst   <= r2_dst;
        r3_sa    <= n3_scaled[30:23];

        r4_src   <= r3_src;
        r4_dst   <= r3_dst;
        r4_sa    <= r3_sa;
        r4_sum_r <= ({8'd0, r3_src.r} * {8'd0, r3_sa}) + ({8'd0, r3_dst.r} * {8'd0, n4_inv});
        r4_sum_g <= ({8'd0, r3_src.g} * {8'd0, r3_sa}) + ({8'd0, r3_dst.g} * {8'd0, n4_inv});
        r4_sum_b <= ({8'd0, r3_src.b} * {8'd0, r3_sa}) + ({8'd0, r3_dst.b} * {8'd0, n4_inv});
        r4_sum_a <= {8'd0, r3_dst.a} * {8'd0, n4_inv};

        r5_res   <= n5_res;
        r5_we    <= n5_we;
    end

    assign o_valid = r5_valid;
    assign o_we    = r5_we;
    assign o_res   = r5_res;

endmodule

### rtl/pbb_pack.sv
// ----------------------------------------------------------------------------
// pbb_pack
// last stage: encodes the result in the destination format, gates the write
// ----------------------------------------------------------------------------
module pbb_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbb_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  logic           i_we,
    input  pbb_pkg::t_argb i_res,
    output logic           o_valid,
    output logic           o_write_enable,
    output logic [31:0]    o_dst_out
);
    import pbb_pkg::*;

    logic        r_valid;
    logic        r_we;
    logic [31:0] r_out;
    logic        n_we;

    // unknown destination format never writes
    assign n_we = i_we && (i_cfg.dst_format <= FMT_IDX8A);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_we  <= n_we;
        r_out <= n_we ? encode_pixel(i_res, i_cfg.dst_format) : 32'd0;
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_we;
    assign o_dst_out      = r_out;

endmodule

### rtl/pixel_blit_blend_pipe_top.sv
// ----------------------------------------------------------------------------
// pixel_blit_blend_pipe_top
// per-pixel blitter datapath: decode, blend and re-encode one pixel per clock
//
// requests: raise start with i_src_raw and i_dst_raw; a request is taken at
// every clock edge where start is high, busy is never asserted, so one pixel
// can be issued every cycle
// results: o_valid strobes for one cycle with o_write_enable and o_dst_out,
// once the request has passed six register stages counted from the input;
// results leave in request order, one per request
// throughput: one pixel per cycle, set by the fully pipelined datapath
// the receiver cannot stall, so no back pressure exists inside the pipe
// configuration: apb writes to src_format, dst_format, blend_mode,
// layer_alpha and key_rgb at byte offsets 0x0 to 0x10; the user must write only while
// no request is in flight, the block does not enforce it; reads return the register values
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module pixel_blit_blend_pipe_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_src_raw,
    input  logic [31:0] i_dst_raw,
    output logic        o_valid,
    output logic        o_write_enable,
    output logic [31:0] o_dst_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pbb_pkg::*;

    t_cfg        r_cfg;
    logic        cfg_wr;
    logic        in_take;
    logic        s1_valid;
    t_argb       s1_src;
    t_argb       s1_dst;
    logic        s5_valid;
    logic        s5_we;
    t_argb       s5_res;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign in_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_format  <= FMT_ARGB8888;
            r_cfg.dst_format  <= FMT_ARGB8888;
            r_cfg.blend_mode  <= MODE_COPY;
            r_cfg.layer_alpha <= 8'hFF;
            r_cfg.key_rgb     <= 24'd0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_SRC_FORMAT:  r_cfg.src_format  <= pwdata[2:0];
                REG_DST_FORMAT:  r_cfg.dst_format  <= pwdata[2:0];
                REG_BLEND_MODE:  r_cfg.blend_mode  <= pwdata[1:0];
                REG_LAYER_ALPHA: r_cfg.layer_alpha <= pwdata[7:0];
                REG_KEY_RGB:     r_cfg.key_rgb     <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SRC_FORMAT:  prdata = {29'd0, r_cfg.src_format};
            REG_DST_FORMAT:  prdata = {29'd0, r_cfg.dst_format};
            REG_BLEND_MODE:  prdata = {30'd0, r_cfg.blend_mode};
            REG_LAYER_ALPHA: prdata = {24'd0, r_cfg.layer_alpha};
            REG_KEY_RGB:     prdata = {8'd0, r_cfg.key_rgb};
            default:         prdata = 32'd0;
        endcase
    end

    pbb_unpack u_unpack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (in_take),
        .i_src_raw (i_src_raw),
        .i_dst_raw (i_dst_raw),
        .o_valid   (s1_valid),
        .o_src     (s1_src),
        .o_dst     (s1_dst)
    );

    pbb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s1_valid),
        .i_src   (s1_src),
        .i_dst   (s1_dst),
        .o_valid (s5_valid),
        .o_we    (s5_we),
        .o_res   (s5_res)
    );

    pbb_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s5_valid),
        .i_we           (s5_we),
        .i_res          (s5_res),
        .o_valid        (o_valid),
        .o_write_enable (o_write_enable),
        .o_dst_out      (o_dst_out)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel blit blend pipe testbench
// Sends pixel requests through every source and destination format and every
// blend mode, and programs the registers over apb between bursts while the
// pipe is empty. A scoreboard predicts the written pixel and write enable of
// each request and checks every result strobe in order. A directed part runs
// first, followed by random register settings and pixels under varied idling.
// ----------------------------------------------------------------------------
module testbench;
    import pbb_pkg::*;

    typedef struct packed {
        logic        we;
        logic [31:0] pix;
    } t_pixel_result;

    class t_blit_scoreboard;
        logic [2:0]    src_fmt;
        logic [2:0]    dst_fmt;
        logic [1:0]    mode;
        logic [7:0]    galpha;
        logic [23:0]   key;
        t_pixel_result expected_q[$];
        int            mismatches;
        int            checked;
        int            suppressed;

        function new();
            src_fmt    = FMT_ARGB8888;
            dst_fmt    = FMT_ARGB8888;
            mode       = MODE_COPY;
            galpha     = 8'hFF;
            key        = '0;
            mismatches = 0;
            checked    = 0;
            suppressed = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_SRC_FORMAT:  src_fmt = value[2:0];
                REG_DST_FORMAT:  dst_fmt = value[2:0];
                REG_BLEND_MODE:  mode    = value[1:0];
                REG_LAYER_ALPHA: galpha  = value[7:0];
                REG_KEY_RGB:     key     = value[23:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input logic [2:0] idx);
            case (idx)
                REG_SRC_FORMAT:  return 32'(src_fmt);
                REG_DST_FORMAT:  return 32'(dst_fmt);
                REG_BLEND_MODE:  return 32'(mode);
                REG_LAYER_ALPHA: return 32'(galpha);
                REG_KEY_RGB:     return 32'(key);
                default:         return '0;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] div255_shift(input logic [31:0] v);
            logic [63:0] p;
            p = 64'(v) * 64'(DIV255_RECIP);
            return p[30:23];
        endfunction

        function logic [31:0] to_argb(input logic [31:0] raw, input logic [2:0] fmt);
            case (fmt)
                FMT_RGB565:   return {8'hFF, raw[15:11], 3'b000, raw[10:5], 2'b00,
                                      raw[4:0], 3'b000};
                FMT_RGBA8888: return {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
                FMT_ARGB8888: return raw;
                FMT_RGBA4444: return {raw[3:0], 4'h0, raw[15:12], 4'h0, raw[11:8], 4'h0,
                                      raw[7:4], 4'h0};
                FMT_IDX8:     return {8'hFF, {3{raw[7:0]}}};
                FMT_IDX8A:    return 32'hFF00_0000;
                default:      return '0;
            endcase
        endfunction

        function logic [31:0] from_argb(input logic [31:0] c, input logic [2:0] fmt);
            case (fmt)
                FMT_RGB565:   return {16'd0, c[23:19], c[15:10], c[7:3]};
                FMT_RGBA8888: return {c[31:24], c[7:0], c[15:8], c[23:16]};
                FMT_ARGB8888: return c;
                FMT_RGBA4444: return {16'd0, c[23:20], c[15:12], c[7:4], c[31:28]};
                default:      return {24'd0, c[7:0]};
            endcase
        endfunction

        function void note_request(input logic [31:0] src_raw, input logic [31:0] dst_raw);
            logic [31:0]   sc;
            logic [31:0]   dc;
            logic [31:0]   res;
            logic [31:0]   sa;
            logic [31:0]   inv;
            logic [8:0]    sum;
            t_pixel_result r;
            sc   = to_argb(src_raw, src_fmt);
            dc   = to_argb(dst_raw, dst_fmt);
            res  = sc;
            r.we = 1'b1;
            case (mode)
                MODE_ALPHA: begin
                    sa  = (32'(sc[31:24]) * 32'(galpha)) / 32'd255;
                    inv = 32'd255 - sa;
                    for (int k = 0; k < 3; k++) begin
                        res[8*k +: 8] = div255_shift(32'(sc[8*k +: 8]) * sa
                                                     + 32'(dc[8*k +: 8]) * inv);
                    end
                    res[31:24] = sa[7:0] + div255_shift(32'(dc[31:24]) * inv);
                end
                MODE_KEY: begin
                    r.we = (sc[23:0] != key);
                end
                MODE_ADD: begin
                    for (int k = 0; k < 3; k++) begin
                        sum = {1'b0, sc[8*k +: 8]} + {1'b0, dc[8*k +: 8]};
                        res[8*k +: 8] = sum[8] ? 8'hFF : sum[7:0];
                    end
                    res[31:24] = 8'hFF;
                end
                default: ;
            endcase
            if (dst_fmt > FMT_IDX8A) r.we = 1'b0;
            r.pix = r.we ? from_argb(res, dst_fmt) : '0;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 50) $display("mismatch: %s", msg);
        endtask

        task check_result(input logic we, input logic [31:0] pix);
            t_pixel_result e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with no request pending we=%0b out=%08h",
                                          we, pix));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (!e.we) suppressed++;
            if (we !== e.we) begin
                report_mismatch($sformatf("write enable %0b, expected %0b", we, e.we));
            end
            if (pix !== e.pix) begin
                report_mismatch($sformatf("dst_out %08h, expected %08h", pix, e.pix));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_src_raw;
    logic [31:0] i_dst_raw;
    logic        o_valid;
    logic        o_write_enable;
    logic [31:0] o_dst_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_blit_scoreboard sb = new();
    int requests = 0;
    int settings = 0;

    pixel_blit_blend_pipe_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_src_raw      (i_src_raw),
        .i_dst_raw      (i_dst_raw),
        .o_valid        (o_valid),
        .o_write_enable (o_write_enable),
        .o_dst_out      (o_dst_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_write_enable, o_dst_out);
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] data;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (data !== sb.reg_value(idx)) begin
            sb.report_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                         idx, data, sb.reg_value(idx)));
        end
    endtask

    // only while the pipe is empty
    task automatic configure(input logic [2:0] sf, input logic [2:0] df,
                             input logic [1:0] bm, input logic [7:0] ga,
                             input logic [23:0] ck);
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        apb_write(REG_SRC_FORMAT, 32'(sf));
        apb_write(REG_DST_FORMAT, 32'(df));
        apb_write(REG_BLEND_MODE, 32'(bm));
        apb_write(REG_LAYER_ALPHA, 32'(ga));
        apb_write(REG_KEY_RGB, 32'(ck));
        check_reg(REG_SRC_FORMAT);
        check_reg(REG_DST_FORMAT);
        check_reg(REG_BLEND_MODE);
        check_reg(REG_LAYER_ALPHA);
        check_reg(REG_KEY_RGB);
        settings++;
    endtask

    task automatic send_pixel(input logic [31:0] s, input logic [31:0] d, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            gap++;
            @(negedge i_clk);
        end
        start     = 1'b1;
        i_src_raw = s;
        i_dst_raw = d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(s, d);
        requests++;
        @(negedge i_clk);
    endtask

    function automatic logic [2:0] pick_format();
        if ($urandom_range(9) == 0) return 3'(6 + $urandom_range(1));
        return 3'($urandom_range(5));
    endfunction

    initial begin
        logic [2:0]  sf;
        logic [2:0]  df;
        logic [1:0]  bm;
        logic [7:0]  ga;
        logic [23:0] ck;
        logic [31:0] key_src;
        logic [31:0] free_bits;
        logic [31:0] argb;
        logic [31:0] s;
        logic [31:0] d;
        int          idle_pct;

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_src_raw = '0;
        i_dst_raw = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values, argb copy
        check_reg(REG_SRC_FORMAT);
        check_reg(REG_DST_FORMAT);
        check_reg(REG_BLEND_MODE);
        check_reg(REG_LAYER_ALPHA);
        check_reg(REG_KEY_RGB);
        send_pixel(32'h0000_0000, 32'h0000_0000, 0);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_pixel(32'hA5A5_A5A5, 32'h5A5A_5A5A, 0);

        configure(FMT_RGB565, FMT_RGBA4444, MODE_COPY, 8'h00, 24'h00_0000);
        send_pixel(32'h0000_FFFF, 32'h0000_0000, 0);
        send_pixel(32'hFFFF_0000, 32'hFFFF_FFFF, 0);

        configure(FMT_RGBA8888, FMT_RGB565, MODE_ALPHA, 8'hFF, 24'hFF_FFFF);
        send_pixel(32'h80FF_0000, 32'h0000_FFFF, 0);
        send_pixel(32'hFF12_3456, 32'h0000_8410, 0);

        configure(FMT_ARGB8888, FMT_RGBA8888, MODE_ALPHA, 8'h00, 24'h12_3456);
        send_pixel(32'hFF80_4020, 32'h1122_3344, 0);

        configure(FMT_RGBA4444, FMT_ARGB8888, MODE_ALPHA, 8'h80, 24'h00_0000);
        send_pixel(32'h0000_F0FF, 32'h80FF_FFFF, 0);
        send_pixel(32'hFFFF_1238, 32'h0000_0000, 0);

        configure(FMT_IDX8, FMT_IDX8, MODE_ADD, 8'h00, 24'h00_0000);
        send_pixel(32'h0000_00FF, 32'h0000_00FF, 0);
        send_pixel(32'hFFFF_FF80, 32'h0000_0090, 0);

        configure(FMT_IDX8A, FMT_IDX8A, MODE_COPY, 8'hFF, 24'h00_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        // color key hit and near miss
        configure(FMT_ARGB8888, FMT_ARGB8888, MODE_KEY, 8'hFF, 24'hFF_FFFF);
        send_pixel(32'h00FF_FFFF, 32'h0000_0000, 0);
        send_pixel(32'h12FF_FFFE, 32'h0000_0000, 0);

        // unknown source formats
        configure(3'd6, FMT_ARGB8888, MODE_COPY, 8'hFF, 24'h00_0000);
        send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 0);
        configure(3'd7, FMT_ARGB8888, MODE_KEY, 8'hFF, 24'h00_0000);
        send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 0);

        // unknown destination formats
        configure(FMT_ARGB8888, 3'd6, MODE_COPY, 8'hFF, 24'h00_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        configure(FMT_ARGB8888, 3'd7, MODE_ADD, 8'hFF, 24'h00_0000);
        send_pixel(32'h8080_8080, 32'hFFFF_FFFF, 0);

        // additive saturation, layer alpha ignored
        configure(FMT_ARGB8888, FMT_ARGB8888, MODE_ADD, 8'h80, 24'h00_0000);
        send_pixel(32'hFF80_8080, 32'hFF80_8080, 0);
        send_pixel(32'h0101_0101, 32'h0202_0202, 0);

        for (int p = 0; p < 16; p++) begin
            sf = pick_format();
            df = pick_format();
            bm = 2'($urandom_range(3));
            case ($urandom_range(3))
                0:       ga = 8'h00;
                1:       ga = 8'hFF;
                default: ga = 8'($urandom);
            endcase
            key_src = $urandom;
            ck      = 24'($urandom);
            if (bm == MODE_KEY) begin
                argb = sb.to_argb(key_src, sf);
                ck   = argb[23:0];
            end
            case (sf)
                FMT_RGB565, FMT_RGBA4444: free_bits = 32'hFFFF_0000;
                FMT_RGBA8888, FMT_ARGB8888: free_bits = 32'hFF00_0000;
                FMT_IDX8: free_bits = 32'hFFFF_FF00;
                default: free_bits = 32'hFFFF_FFFF;
            endcase
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 79;
                default: idle_pct = 6;
            endcase
            configure(sf, df, bm, ga, ck);
            for (int n = 0; n < 100; n++) begin
                s = $urandom;
                d = $urandom;
                if (bm == MODE_KEY && $urandom_range(2) == 0) begin
                    s = key_src ^ ($urandom & free_bits);
                end else if ($urandom_range(7) == 0) begin
                    s = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end
                if ($urandom_range(7) == 0) d = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                send_pixel(s, d, idle_pct);
            end
        end

        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("%0d pixel requests under %0d register settings across all formats and modes",
                 requests, settings);
        $display("%0d results checked, %0d of them with the write suppressed",
                 sb.checked, sb.suppressed);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
